### src/assert_macros.svh
// Assertion macros used by the top level of the segment/box slab test.
// No dependencies; the bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SBSI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define SBSI_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define SBSI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SBSI_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

### src/sbsi_pkg.sv
// Types and constants of the segment/box slab test.
// No dependencies.
package sbsi_pkg;

    typedef logic signed [31:0] fx_t;
    typedef logic signed [32:0] fxd_t;

    typedef struct packed {
        fx_t origin_x;
        fx_t origin_y;
        fx_t origin_z;
        fx_t dir_x;
        fx_t dir_y;
        fx_t dir_z;
        fx_t box_min_x;
        fx_t box_min_y;
        fx_t box_min_z;
        fx_t box_max_x;
        fx_t box_max_y;
        fx_t box_max_z;
    } in_word_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] kind;
        fx_t        point_x;
        fx_t        point_y;
        fx_t        point_z;
    } out_word_t;

    // classified item passed from front to back
    typedef struct packed {
        logic [2:0]       clip;
        logic             deg_miss;
        fx_t  [2:0]       org;
        fx_t  [2:0]       dir;
        fxd_t [2:0]       diff_lo;
        fxd_t [2:0]       diff_hi;
    } job_t;

    // what the back end carries alongside the dividers
    typedef struct packed {
        logic [2:0] clip;
        logic       deg_miss;
        fx_t  [2:0] org;
        fx_t  [2:0] dir;
    } side_t;

    localparam logic [1:0] KIND_MISS  = 2'd0;
    localparam logic [1:0] KIND_ENTRY = 2'd1;
    localparam logic [1:0] KIND_EXIT  = 2'd2;
    localparam logic [1:0] KIND_CONT  = 2'd3;

    localparam logic [0:0] CFG_EPSILON = 1'd0;
    localparam logic [0:0] CFG_CONT    = 1'd1;

    localparam fx_t FX_MAX = 32'sh7FFF_FFFF;
    localparam fx_t FX_MIN = 32'sh8000_0000;

    // divider: input register, 32 quotient stages, saturation register
    localparam int DIV_LAT = 34;

endpackage

### src/segment_box_slab_intersect.sv
// Top level of the segment versus axis-aligned box slab test.
// Depends on sbsi_pkg, sbsi_front, sbsi_queue, sbsi_back and assert_macros.svh.
`include "assert_macros.svh"

// Segment/box slab test. One word (segment origin and direction plus two box
// corners, all signed fixed point) is taken per clock while busy is low; each
// word yields exactly one result word, shown for one cycle with done high,
// once it has passed the front register, the queue, the dividers and stages
// A to E, in acceptance order. The receiver cannot hold results off and need
// not: the back end never stalls, so the queue between front and back drains
// every cycle and busy stays low in normal running. Most of the pipeline is
// the six slab dividers, each a 34-deep pipeline producing one quotient bit
// per stage; throughput is one word per clock while busy is low. Write
// epsilon and containment_counts only while no word is in flight.
module segment_box_slab_intersect
    import sbsi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_word_t    item,
    output logic        done,
    output out_word_t   result,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] eps_reg;
    logic        cont_reg;

    logic        accept;
    logic        f_valid;
    job_t        f_job;
    logic        q_valid;
    job_t        q_head;
    logic        q_full;

    logic        pt_zero;
    logic        pt_max;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg  <= 16'd1;
            cont_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EPSILON: eps_reg  <= cfg_data;
                CFG_CONT:    cont_reg <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    assign busy   = q_full;
    assign accept = start && !busy;

    // front: near-zero axes, origin-in-slab test, slab differences
    sbsi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .eps       (eps_reg),
        .job_valid (f_valid),
        .job       (f_job)
    );

    // back end pops every cycle it has a word
    sbsi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_valid),
        .push_job   (f_job),
        .pop        (1'b1),
        .head_valid (q_valid),
        .head       (q_head),
        .full       (q_full)
    );

    sbsi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (q_valid),
        .job         (q_head),
        .eps         (eps_reg),
        .cont_counts (cont_reg),
        .done        (done),
        .result      (result)
    );

    assign pt_zero = (result.point_x == '0) && (result.point_y == '0)
                     && (result.point_z == '0);
    assign pt_max  = (result.point_x == FX_MAX) && (result.point_y == FX_MAX)
                     && (result.point_z == FX_MAX);

    // hit flag agrees with kind
    `SBSI_ASSERT_IMPL(a_hit_kind, clk, rst_n, done, result.hit == (result.kind != KIND_MISS))
    // a miss reports the origin of coordinates
    `SBSI_ASSERT_IMPL(a_miss_zero, clk, rst_n, done && (result.kind == KIND_MISS), pt_zero)
    // containment reports the saturated point
    `SBSI_ASSERT_IMPL(a_cont_max, clk, rst_n, done && (result.kind == KIND_CONT), pt_max)
    // containment only when enabled
    `SBSI_ASSERT_NEVER(a_cont_en, clk, rst_n, done && (result.kind == KIND_CONT) && !cont_reg)

endmodule

### src/sbsi_front.sv
// Front end: accepts a word, flags near-zero axes and slab differences.
// Depends on sbsi_pkg.
module sbsi_front
    import sbsi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  in_word_t    item,
    input  logic [15:0] eps,
    output logic        job_valid,
    output job_t        job
);

    fx_t        o [3];
    fx_t        d [3];
    fx_t        lo [3];
    fx_t        hi [3];
    job_t       job_next;
    logic       job_valid_reg;
    job_t       job_reg;

    assign o[0]  = item.origin_x;
    assign o[1]  = item.origin_y;
    assign o[2]  = item.origin_z;
    assign d[0]  = item.dir_x;
    assign d[1]  = item.dir_y;
    assign d[2]  = item.dir_z;
    assign lo[0] = item.box_min_x;
    assign lo[1] = item.box_min_y;
    assign lo[2] = item.box_min_z;
    assign hi[0] = item.box_max_x;
    assign hi[1] = item.box_max_y;
    assign hi[2] = item.box_max_z;

    always_comb
    begin
        logic [32:0] mag;
        fx_t         l;
        fx_t         h;
        job_next = '0;
        for (int a = 0; a < 3; a++)
        begin
            mag = d[a][31] ? (33'd0 - {d[a][31], d[a]}) : {1'b0, d[a]};
            job_next.clip[a] = (d[a] != 32'sd0) && (mag >= {17'd0, eps});
            l = (lo[a] < hi[a]) ? lo[a] : hi[a];
            h = (lo[a] < hi[a]) ? hi[a] : lo[a];
            if (!job_next.clip[a] && ((o[a] < l) || (o[a] > h)))
                job_next.deg_miss = 1'b1;
            job_next.org[a]     = o[a];
            job_next.dir[a]     = d[a];
            job_next.diff_lo[a] = $signed({lo[a][31], lo[a]}) - $signed({o[a][31], o[a]});
            job_next.diff_hi[a] = $signed({hi[a][31], hi[a]}) - $signed({o[a][31], o[a]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            job_valid_reg <= 1'b0;
        else
            job_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            job_reg <= job_next;
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

### src/sbsi_queue.sv
// Two-word queue between front and back end.
// Depends on sbsi_pkg.
module sbsi_queue
    import sbsi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic head_valid,
    output job_t head,
    output logic full
);

    job_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_pop;

    assign do_pop     = pop && (count_reg != 2'd0);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem[rd_ptr_reg];
    assign full       = (count_reg == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (!push && do_pop)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule

### src/sbsi_div.sv
// Pipelined signed divider, one quotient bit per stage, int32 saturation.
// Depends on sbsi_pkg.
module sbsi_div
    import sbsi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic signed [33+FRAC_BITS-1:0] num,
    input  fx_t                           den,
    output fx_t                           quo
);

    localparam int NW = 33 + FRAC_BITS;
    localparam int RW = (NW > 64) ? NW : 64;

    logic [RW-1:0] rem_reg  [33];
    logic [31:0]   q_reg    [33];
    logic [31:0]   dmag_reg [33];
    logic          neg_reg  [33];
    logic          ovf_reg  [33];
    fx_t           quo_reg;

    logic [RW-1:0] nmag;
    logic [31:0]   dmag;

    always_comb
    begin
        logic [RW-1:0] num_ext;
        num_ext = {{(RW-NW){num[NW-1]}}, num};
        nmag    = num[NW-1] ? ({RW{1'b0}} - num_ext) : num_ext;
        dmag    = den[31] ? (32'd0 - den) : den;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= nmag;
        q_reg[0]    <= '0;
        dmag_reg[0] <= dmag;
        neg_reg[0]  <= num[NW-1] ^ den[31];
        ovf_reg[0]  <= nmag >= {{(RW-64){1'b0}}, dmag, 32'd0};
    end

    for (genvar k = 0; k < 32; k++)
    begin : g_stage
        logic [RW-1:0] sh;
        logic          ge;
        assign sh = {{(RW-32){1'b0}}, dmag_reg[k]} << (31 - k);
        assign ge = rem_reg[k] >= sh;
        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= ge ? (rem_reg[k] - sh) : rem_reg[k];
            q_reg[k+1]    <= q_reg[k] | ({31'd0, ge} << (31 - k));
            dmag_reg[k+1] <= dmag_reg[k];
            neg_reg[k+1]  <= neg_reg[k];
            ovf_reg[k+1]  <= ovf_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!neg_reg[32])
            quo_reg <= (ovf_reg[32] || q_reg[32][31]) ? FX_MAX : $signed(q_reg[32]);
        else if (ovf_reg[32] || (q_reg[32] > 32'h8000_0000))
            quo_reg <= FX_MIN;
        else
            quo_reg <= $signed(32'd0 - q_reg[32]);
    end

    assign quo = quo_reg;

endmodule

### src/sbsi_back.sv
// Back end: slab dividers, interval clipping, point evaluation.
// Depends on sbsi_pkg and sbsi_div.
module sbsi_back
    import sbsi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  job_t        job,
    input  logic [15:0] eps,
    input  logic        cont_counts,
    output logic        done,
    output out_word_t   result
);

    localparam logic signed [33:0] FX_ONE = 34'sd1 <<< FRAC_BITS;

    fx_t   q_lo [3];
    fx_t   q_hi [3];

    logic  vpipe_reg [DIV_LAT];
    side_t spipe_reg [DIV_LAT];

    // stage A: ordered slab parameters
    logic  va_reg;
    side_t sa_reg;
    fx_t   ta_lo_reg [3];
    fx_t   ta_hi_reg [3];
    // stage B: clipped interval
    logic  vb_reg;
    side_t sb_reg;
    fx_t   tmin_reg;
    fx_t   tmax_reg;
    // stage C: classification
    logic       vc_reg;
    logic [1:0] kc_reg;
    fx_t        tc_reg;
    fx_t        oc_reg [3];
    fx_t        dc_reg [3];
    // stage D: products
    logic                vd_reg;
    logic [1:0]          kd_reg;
    fx_t                 od_reg [3];
    logic signed [63:0]  pd_reg [3];
    // output
    logic      done_reg;
    out_word_t result_reg;

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        sbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
            .clk (clk),
            .num ($signed({job.diff_lo[a], {FRAC_BITS{1'b0}}})),
            .den (job.dir[a]),
            .quo (q_lo[a])
        );
        sbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
            .clk (clk),
            .num ($signed({job.diff_hi[a], {FRAC_BITS{1'b0}}})),
            .den (job.dir[a]),
            .quo (q_hi[a])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
                vpipe_reg[i] <= 1'b0;
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            vd_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vpipe_reg[0] <= job_valid;
            for (int i = 1; i < DIV_LAT; i++)
                vpipe_reg[i] <= vpipe_reg[i-1];
            va_reg   <= vpipe_reg[DIV_LAT-1];
            vb_reg   <= va_reg;
            vc_reg   <= vb_reg;
            vd_reg   <= vc_reg;
            done_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        spipe_reg[0] <= '{clip: job.clip, deg_miss: job.deg_miss, org: job.org, dir: job.dir};
        for (int i = 1; i < DIV_LAT; i++)
            spipe_reg[i] <= spipe_reg[i-1];
    end

    // stage A: non-clipping axes give the neutral interval
    always_ff @(posedge clk)
    begin
        sa_reg <= spipe_reg[DIV_LAT-1];
        for (int a = 0; a < 3; a++)
        begin
            if (!spipe_reg[DIV_LAT-1].clip[a])
            begin
                ta_lo_reg[a] <= '0;
                ta_hi_reg[a] <= fx_t'(FX_ONE);
            end
            else if (q_lo[a] > q_hi[a])
            begin
                ta_lo_reg[a] <= q_hi[a];
                ta_hi_reg[a] <= q_lo[a];
            end
            else
            begin
                ta_lo_reg[a] <= q_lo[a];
                ta_hi_reg[a] <= q_hi[a];
            end
        end
    end

    // stage B
    always_ff @(posedge clk)
    begin
        fx_t mn;
        fx_t mx;
        mn = '0;
        mx = fx_t'(FX_ONE);
        for (int a = 0; a < 3; a++)
        begin
            if (ta_lo_reg[a] > mn)
                mn = ta_lo_reg[a];
            if (ta_hi_reg[a] < mx)
                mx = ta_hi_reg[a];
        end
        sb_reg   <= sa_reg;
        tmin_reg <= mn;
        tmax_reg <= mx;
    end

    // stage C
    always_ff @(posedge clk)
    begin
        logic signed [33:0] eps_s;
        logic               start_in;
        logic               end_in;
        fx_t                t_sel;
        eps_s    = $signed({18'd0, eps});
        start_in = $signed({{2{tmin_reg[31]}}, tmin_reg}) < eps_s;
        end_in   = (FX_ONE - $signed({{2{tmax_reg[31]}}, tmax_reg})) < eps_s;
        t_sel    = tmin_reg;
        for (int a = 0; a < 3; a++)
        begin
            oc_reg[a] <= sb_reg.org[a];
            dc_reg[a] <= sb_reg.dir[a];
        end
        if (sb_reg.deg_miss || (tmin_reg > tmax_reg))
            kc_reg <= KIND_MISS;
        else if (start_in && end_in)
            kc_reg <= cont_counts ? KIND_CONT : KIND_MISS;
        else if (start_in)
        begin
            kc_reg <= KIND_EXIT;
            t_sel  = tmax_reg;
        end
        else
            kc_reg <= KIND_ENTRY;
        tc_reg <= t_sel;
    end

    // stage D
    always_ff @(posedge clk)
    begin
        kd_reg <= kc_reg;
        for (int a = 0; a < 3; a++)
        begin
            od_reg[a] <= oc_reg[a];
            pd_reg[a] <= tc_reg * dc_reg[a];
        end
    end

    // stage E: floor scale, add origin, saturate; a miss gives zero, containment the maximum
    always_ff @(posedge clk)
    begin
        logic signed [64:0] s;
        fx_t                pt [3];
        for (int a = 0; a < 3; a++)
        begin
            s = $signed({{33{od_reg[a][31]}}, od_reg[a]})
                + $signed({pd_reg[a][63], (pd_reg[a] >>> FRAC_BITS)});
            if (s > 65'sd2147483647)
                pt[a] = FX_MAX;
            else if (s < -65'sd2147483648)
                pt[a] = FX_MIN;
            else
                pt[a] = s[31:0];
            if (kd_reg == KIND_MISS)
                pt[a] = '0;
            else if (kd_reg == KIND_CONT)
                pt[a] = FX_MAX;
        end
        result_reg.hit     <= (kd_reg != KIND_MISS);
        result_reg.kind    <= kd_reg;
        result_reg.point_x <= pt[0];
        result_reg.point_y <= pt[1];
        result_reg.point_z <= pt[2];
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
